/* rtl/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// Delta-list timer queue: shared package
// Sizes, operation and status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dltq_pkg;

    // Table size. One slot always stays empty as the end of the list.
    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int DELTA_W = 31;
    localparam int ID_W    = 32;
    localparam int ARG_W   = 32;

    // Operation codes carried on the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Status codes returned with each result beat.
    localparam logic STAT_ADDED     = 1'b0;
    localparam logic STAT_FULL      = 1'b1;
    localparam logic STAT_NOT_FOUND = 1'b0;
    localparam logic STAT_REMOVED   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_REPLY
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new request and rewind the walk
        logic step;        // advance the walk by one slot
        logic commit_ins;  // open a gap at the walk position and write the entry
        logic commit_rem;  // close the list over the walk position
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_remove;   // the captured request is a remove
        logic reject;      // request cannot proceed (zero handler, or table full on an insert)
        logic stop;        // walk has reached its place or the end of the list
        logic hit;         // remove walk sits on a matching entry
    } dp_stat_t;

endpackage

/* rtl/delta_list_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// Delta-list timer queue: top level
// Sorted timer table with insert and remove requests and one status beat
// per request.
// ----------------------------------------------------------------------------
// The table holds up to 15 live timers in expiry order, each stored as a
// handler id, an argument and a delay relative to the timer before it. An
// insert (func 0) returns status 0 when added and 1 when the table is full or
// the handler is zero; a remove (func 1) drops the first timer whose handler
// and argument match and returns 1, or returns 0 when nothing matches. A
// request is captured at the accepting edge, then walks the list one slot per
// cycle until it stops at its place or at the end of the list, and posts its
// result from the reply state; the input is stalled for that whole time, so a
// new request is not taken before the last one has posted its result. The
// final shift of the table moves every slot at once, in the cycle in which the
// walk stops. One request is in flight at a time; the result sits in an output
// register, so the next request is taken while an earlier result still waits,
// and only a result that is still stalled when the next one is ready holds
// that one back in the reply state.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top
    import dltq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [ID_W-1:0]    handler_id,
    input  logic [ARG_W-1:0]   argument,
    input  logic [DELTA_W-1:0] delay_ticks,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer and result register.
    dltq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Slot table, walk and shift.
    dltq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .handler_id  (handler_id),
        .argument    (argument),
        .delay_ticks (delay_ticks),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

/* rtl/dltq_ctrl.sv */
// ----------------------------------------------------------------------------
// Delta-list timer queue: controller
// Sequences one request at a time through the walk and the commit, and holds
// the result beat until the output side takes it.
// ----------------------------------------------------------------------------
module dltq_ctrl
    import dltq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output logic     status,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   result_reg;
    logic   result_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   status_reg;
    logic   status_next;

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // Next state, datapath commands and the output register.
    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        cmd            = '0;

        // A waiting beat leaves once the output side takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.reject)
                begin
                    result_next = stat.is_remove ? STAT_NOT_FOUND : STAT_FULL;
                    state_next  = S_REPLY;
                end
                else if (!stat.stop)
                begin
                    cmd.step = 1'b1;
                end
                else if (!stat.is_remove)
                begin
                    cmd.commit_ins = 1'b1;
                    result_next    = STAT_ADDED;
                    state_next     = S_REPLY;
                end
                else
                begin
                    cmd.commit_rem = stat.hit;
                    result_next    = stat.hit ? STAT_REMOVED : STAT_NOT_FOUND;
                    state_next     = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // A request is only taken while idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("request captured outside idle");

    // Every commit is followed by a reply.
    a_commit_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_ins || cmd.commit_rem) |=> state_reg == S_REPLY)
        else $error("commit not followed by a reply");

    // Insert and remove never commit together.
    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit_ins && cmd.commit_rem))
        else $error("insert and remove committed in one cycle");

endmodule

/* rtl/dltq_datapath.sv */
// ----------------------------------------------------------------------------
// Delta-list timer queue: datapath
// Holds the slot table and the live count, walks the list one slot per cycle
// and opens or closes a gap over the whole table at once.
// ----------------------------------------------------------------------------
module dltq_datapath
    import dltq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 func,
    input  logic [ID_W-1:0]      handler_id,
    input  logic [ARG_W-1:0]     argument,
    input  logic [DELTA_W-1:0]   delay_ticks,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int CW = IDX_W + 1;

    // Slot table. Slot contents at or beyond the live count never affect a result.
    logic [DELTA_W-1:0] delta_reg   [SLOTS];
    logic [ID_W-1:0]    handler_reg [SLOTS];
    logic [ARG_W-1:0]   arg_reg     [SLOTS];

    // Captured request and walk state.
    logic               func_reg;
    logic [ID_W-1:0]    req_handler_reg;
    logic [ARG_W-1:0]   req_arg_reg;
    logic [DELTA_W-1:0] t_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   count_reg;

    // Neighbour values seen by each slot, zero past either end.
    logic [DELTA_W-1:0] above_delta   [SLOTS];
    logic [ID_W-1:0]    above_handler [SLOTS];
    logic [ARG_W-1:0]   above_arg     [SLOTS];
    logic [DELTA_W-1:0] below_delta   [SLOTS];
    logic [ID_W-1:0]    below_handler [SLOTS];
    logic [ARG_W-1:0]   below_arg     [SLOTS];

    logic [DELTA_W-1:0] cur_delta;
    logic               at_end;
    logic               handler_zero;
    logic               full;
    logic               match;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_nbr
        if (k < SLOTS - 1)
        begin : g_above
            assign above_delta[k]   = delta_reg[k+1];
            assign above_handler[k] = handler_reg[k+1];
            assign above_arg[k]     = arg_reg[k+1];
        end
        else
        begin : g_top
            assign above_delta[k]   = '0;
            assign above_handler[k] = '0;
            assign above_arg[k]     = '0;
        end
        if (k > 0)
        begin : g_below
            assign below_delta[k]   = delta_reg[k-1];
            assign below_handler[k] = handler_reg[k-1];
            assign below_arg[k]     = arg_reg[k-1];
        end
        else
        begin : g_bottom
            assign below_delta[k]   = '0;
            assign below_handler[k] = '0;
            assign below_arg[k]     = '0;
        end
    end

    // Walk position decode.
    assign cur_delta    = delta_reg[idx_reg];
    assign at_end       = (idx_reg == count_reg);
    assign handler_zero = (req_handler_reg == '0);
    assign full         = (count_reg == IDX_W'(SLOTS - 1));
    assign match        = !at_end && (handler_reg[idx_reg] == req_handler_reg)
                          && (arg_reg[idx_reg] == req_arg_reg);

    always_comb
    begin
        stat.is_remove = (func_reg == FUNC_REMOVE);
        stat.reject    = handler_zero || ((func_reg == FUNC_INSERT) && full);
        stat.hit       = match;
        if (func_reg == FUNC_REMOVE)
        begin
            stat.stop = at_end || match;
        end
        else
        begin
            stat.stop = at_end || (cur_delta > t_reg);
        end
    end

    // Request capture, walk index, remaining delay and live count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.commit_ins)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.commit_rem)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg        <= func;
            req_handler_reg <= handler_id;
            req_arg_reg     <= argument;
            t_reg           <= delay_ticks;
        end
        else if (cmd.step && (func_reg == FUNC_INSERT))
        begin
            t_reg <= t_reg - cur_delta;
        end
    end

    // Table update: each slot looks only at itself and its two neighbours.
    always_ff @(posedge clk)
    begin
        logic [CW-1:0]      kk;
        logic [CW-1:0]      pos;
        logic [CW-1:0]      cnt;
        logic [DELTA_W:0]   sum;
        for (int k = 0; k < SLOTS; k++)
        begin
            kk  = CW'(k);
            pos = {1'b0, idx_reg};
            cnt = {1'b0, count_reg};
            sum = {1'b0, delta_reg[k]} + {1'b0, above_delta[k]};
            if (cmd.commit_ins)
            begin
                if (kk == pos)
                begin
                    delta_reg[k]   <= t_reg;
                    handler_reg[k] <= req_handler_reg;
                    arg_reg[k]     <= req_arg_reg;
                end
                else if ((kk == pos + 1'b1) && (kk <= cnt))
                begin
                    // Entry pushed up behind the new one loses the new delay.
                    delta_reg[k]   <= below_delta[k] - t_reg;
                    handler_reg[k] <= below_handler[k];
                    arg_reg[k]     <= below_arg[k];
                end
                else if ((kk > pos) && (kk <= cnt))
                begin
                    delta_reg[k]   <= below_delta[k];
                    handler_reg[k] <= below_handler[k];
                    arg_reg[k]     <= below_arg[k];
                end
            end
            else if (cmd.commit_rem)
            begin
                if ((kk == pos) && (kk + 1'b1 < cnt))
                begin
                    // Successor absorbs the removed delay, saturating.
                    delta_reg[k]   <= sum[DELTA_W] ? '1 : sum[DELTA_W-1:0];
                    handler_reg[k] <= above_handler[k];
                    arg_reg[k]     <= above_arg[k];
                end
                else if ((kk > pos) && (kk + 1'b1 < cnt))
                begin
                    delta_reg[k]   <= above_delta[k];
                    handler_reg[k] <= above_handler[k];
                    arg_reg[k]     <= above_arg[k];
                end
            end
        end
    end

    // An insert adds exactly one live entry.
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_ins |=> count_reg == IDX_W'($past(count_reg) + 1'b1))
        else $error("insert did not grow the live count by one");

    // A remove takes away exactly one live entry.
    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_rem |=> count_reg == IDX_W'($past(count_reg) - 1'b1))
        else $error("remove did not shrink the live count by one");

    // The walk never runs past the end of the list.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load |=> idx_reg <= count_reg)
        else $error("walk index beyond the live count");

    // An insert never commits into a full table, nor removes from an empty one.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_ins |-> count_reg < IDX_W'(SLOTS - 1))
        and (cmd.commit_rem |-> count_reg != '0))
        else $error("commit against a full or empty table");

endmodule
